FILE: rtl/ordered_value_list_engine_defines.svh
// ----------------------------------------------------------------------------
// ordered value list engine assertion macros
// clocked on clk, disabled while rst_n is low
// ----------------------------------------------------------------------------
`ifndef ORDERED_VALUE_LIST_ENGINE_DEFINES_SVH
`define ORDERED_VALUE_LIST_ENGINE_DEFINES_SVH

`ifndef SYNTHESIS
// antecedent implies consequent in the same cycle
`define OVLE_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// antecedent implies consequent in the next cycle
`define OVLE_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define OVLE_ASSERT_NOW(lbl, ante, cons, msg)
`define OVLE_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

FILE: rtl/ovle_pkg.sv
// ----------------------------------------------------------------------------
// ovle_pkg
// shared constants, codes and types of the ordered value list engine
// ----------------------------------------------------------------------------
package ovle_pkg;

    localparam int CAPACITY = 64;
    localparam int ADDR_W   = $clog2(CAPACITY);
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int VALUE_W  = 32;
    localparam int POS_W    = 6;
    localparam int COUNT_W  = 7;

    typedef enum logic [1:0] {
        OP_APPEND = 2'd0,
        OP_REMOVE = 2'd1,
        OP_FIND   = 2'd2,
        OP_CLEAR  = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        ST_DONE      = 2'd0,
        ST_NOT_FOUND = 2'd1,
        ST_EMPTY     = 2'd2,
        ST_FULL      = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SEARCH,
        S_SHIFT,
        S_FINISH
    } state_t;

    typedef struct packed {
        logic               we;
        logic [ADDR_W-1:0]  waddr;
        logic [VALUE_W-1:0] wdata;
        logic [ADDR_W-1:0]  raddr;
    } mem_req_t;

    typedef struct packed {
        logic               valid;
        status_t            status;
        logic [POS_W-1:0]   position;
        logic [COUNT_W-1:0] entry_count;
        logic               is_empty;
    } res_t;

endpackage

FILE: rtl/ovle_ram.sv
// ----------------------------------------------------------------------------
// ovle_ram
// generic single write port, single read port ram with registered read
// ----------------------------------------------------------------------------
module ovle_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

FILE: rtl/ovle_ctrl.sv
// ----------------------------------------------------------------------------
// ovle_ctrl
// list sequencer: append, clear, linear search and compaction over the entry ram
// ----------------------------------------------------------------------------
`include "ordered_value_list_engine_defines.svh"

module ovle_ctrl (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    input  ovle_pkg::op_t                in_op,
    input  logic [ovle_pkg::VALUE_W-1:0] in_value,
    output logic                         in_ready,
    output ovle_pkg::mem_req_t           mem_req,
    input  logic [ovle_pkg::VALUE_W-1:0] mem_rdata,
    output ovle_pkg::res_t               res,
    input  logic                         res_take
);

    ovle_pkg::state_t              state_reg, state_next;
    ovle_pkg::op_t                 op_reg, op_next;
    logic [ovle_pkg::VALUE_W-1:0]  value_reg, value_next;
    logic [ovle_pkg::ADDR_W-1:0]   idx_reg, idx_next;
    logic [ovle_pkg::CNT_W-1:0]    count_reg, count_next;
    ovle_pkg::status_t             status_reg, status_next;
    logic [ovle_pkg::ADDR_W-1:0]   pos_reg, pos_next;

    logic [ovle_pkg::CNT_W-1:0]                     idx_inc;
    logic [ovle_pkg::CNT_W-1:0]                     idx_plus2;
    logic [ovle_pkg::ADDR_W+ovle_pkg::POS_W-1:0]    pos_wide;
    logic [ovle_pkg::CNT_W+ovle_pkg::COUNT_W-1:0]   count_wide;

    assign idx_inc   = ovle_pkg::CNT_W'(idx_reg) + ovle_pkg::CNT_W'(1);
    assign idx_plus2 = ovle_pkg::CNT_W'(idx_reg) + ovle_pkg::CNT_W'(2);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ovle_pkg::S_IDLE;
            count_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg     <= op_next;
        value_reg  <= value_next;
        idx_reg    <= idx_next;
        status_reg <= status_next;
        pos_reg    <= pos_next;
    end

    always_comb
    begin
        state_next    = state_reg;
        op_next       = op_reg;
        value_next    = value_reg;
        idx_next      = idx_reg;
        count_next    = count_reg;
        status_next   = status_reg;
        pos_next      = pos_reg;
        in_ready      = 1'b0;
        mem_req.we    = 1'b0;
        mem_req.waddr = count_reg[ovle_pkg::ADDR_W-1:0];
        mem_req.wdata = value_reg;
        mem_req.raddr = idx_inc[ovle_pkg::ADDR_W-1:0];

        case (state_reg)
            ovle_pkg::S_IDLE:
            begin
                in_ready      = 1'b1;
                mem_req.raddr = '0;
                mem_req.wdata = in_value;
                if (in_valid)
                begin
                    op_next     = in_op;
                    value_next  = in_value;
                    idx_next    = '0;
                    pos_next    = '0;
                    status_next = ovle_pkg::ST_DONE;
                    state_next  = ovle_pkg::S_FINISH;
                    case (in_op)
                        ovle_pkg::OP_APPEND:
                        begin
                            if (count_reg >= ovle_pkg::CNT_W'(ovle_pkg::CAPACITY))
                            begin
                                status_next = ovle_pkg::ST_FULL;
                            end
                            else
                            begin
                                mem_req.we = 1'b1;
                                count_next = count_reg + ovle_pkg::CNT_W'(1);
                            end
                        end
                        ovle_pkg::OP_CLEAR:
                        begin
                            count_next = '0;
                        end
                        default:
                        begin
                            if (count_reg == '0)
                            begin
                                status_next = ovle_pkg::ST_EMPTY;
                            end
                            else
                            begin
                                state_next = ovle_pkg::S_SEARCH;
                            end
                        end
                    endcase
                end
            end

            ovle_pkg::S_SEARCH:
            begin
                if (mem_rdata == value_reg)
                begin
                    if (op_reg == ovle_pkg::OP_FIND)
                    begin
                        pos_next   = idx_reg;
                        state_next = ovle_pkg::S_FINISH;
                    end
                    else if (idx_inc < count_reg)
                    begin
                        state_next = ovle_pkg::S_SHIFT;
                    end
                    else
                    begin
                        count_next = count_reg - ovle_pkg::CNT_W'(1);
                        state_next = ovle_pkg::S_FINISH;
                    end
                end
                else if (idx_inc >= count_reg)
                begin
                    status_next = ovle_pkg::ST_NOT_FOUND;
                    state_next  = ovle_pkg::S_FINISH;
                end
                else
                begin
                    idx_next = idx_inc[ovle_pkg::ADDR_W-1:0];
                end
            end

            ovle_pkg::S_SHIFT:
            begin
                // move entry idx+1 down to idx while fetching idx+2
                mem_req.we    = 1'b1;
                mem_req.waddr = idx_reg;
                mem_req.wdata = mem_rdata;
                mem_req.raddr = idx_plus2[ovle_pkg::ADDR_W-1:0];
                if (idx_plus2 < count_reg)
                begin
                    idx_next = idx_inc[ovle_pkg::ADDR_W-1:0];
                end
                else
                begin
                    count_next = count_reg - ovle_pkg::CNT_W'(1);
                    state_next = ovle_pkg::S_FINISH;
                end
            end

            ovle_pkg::S_FINISH:
            begin
                if (res_take)
                begin
                    state_next = ovle_pkg::S_IDLE;
                end
            end

            default:
            begin
                state_next = ovle_pkg::S_IDLE;
            end
        endcase
    end

    assign pos_wide        = {{ovle_pkg::POS_W{1'b0}}, pos_reg};
    assign count_wide      = {{ovle_pkg::COUNT_W{1'b0}}, count_reg};
    assign res.valid       = (state_reg == ovle_pkg::S_FINISH);
    assign res.status      = status_reg;
    assign res.position    = pos_wide[ovle_pkg::POS_W-1:0];
    assign res.entry_count = count_wide[ovle_pkg::COUNT_W-1:0];
    assign res.is_empty    = (count_reg == '0);

    `OVLE_ASSERT_NOW(a_count_cap, 1'b1, count_reg <= ovle_pkg::CNT_W'(ovle_pkg::CAPACITY), "count over capacity")
    `OVLE_ASSERT_NOW(a_search_idx, state_reg == ovle_pkg::S_SEARCH, ovle_pkg::CNT_W'(idx_reg) < count_reg, "search index past count")
    `OVLE_ASSERT_NEXT(a_clear, in_valid && in_ready && in_op == ovle_pkg::OP_CLEAR, count_reg == '0, "clear left entries")
    `OVLE_ASSERT_NOW(a_write_state, mem_req.we, state_reg == ovle_pkg::S_IDLE || state_reg == ovle_pkg::S_SHIFT, "ram write outside append or shift")

endmodule

FILE: rtl/ordered_value_list_engine.sv
// ----------------------------------------------------------------------------
// ordered_value_list_engine
// ordered list of signed 32-bit values with append, remove, find and clear
// ----------------------------------------------------------------------------
// usage:
//   input stream s_*: s_tuser carries the opcode, s_tdata the value
//   output stream m_*: one result per input transfer, m_tuser status,
//   m_tdata position, entry count and empty flag
//   one item is in work at a time; s_tready is high only when idle
//   append and clear: finish straight from idle, then the result is
//   registered into the output stream; find and remove search from
//   position 0 upward to the first match or to the count; a remove then
//   moves the entries above the match down one per cycle through the ram
//   the walk rate is one entry per cycle, set by the single read port
//   of the entry ram and its registered read
//   at reset the list is empty; the ram needs no clearing pass
//   a stalled result sits in the output register; the engine holds its
//   finished result until that register frees, then takes new input
// ----------------------------------------------------------------------------
module ordered_value_list_engine (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // value[31:0]
    input  logic [1:0]  s_tuser,   // opcode[1:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // position[5:0], entry_count[12:6], is_empty[13], zero[15:14]
    output logic [1:0]  m_tuser    // status[1:0]
);

    ovle_pkg::mem_req_t           mem_req;
    logic [ovle_pkg::VALUE_W-1:0] mem_rdata;
    ovle_pkg::res_t               res;
    logic                         res_take;

    logic        m_tvalid_reg;
    logic [15:0] m_tdata_reg;
    logic [1:0]  m_tuser_reg;

    ovle_ram #(
        .WIDTH (ovle_pkg::VALUE_W),
        .DEPTH (ovle_pkg::CAPACITY)
    ) u_entry_ram (
        .clk   (clk),
        .we    (mem_req.we),
        .waddr (mem_req.waddr),
        .wdata (mem_req.wdata),
        .raddr (mem_req.raddr),
        .rdata (mem_rdata)
    );

    ovle_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_op     (ovle_pkg::op_t'(s_tuser)),
        .in_value  (s_tdata),
        .in_ready  (s_tready),
        .mem_req   (mem_req),
        .mem_rdata (mem_rdata),
        .res       (res),
        .res_take  (res_take)
    );

    assign res_take = res.valid && (!m_tvalid_reg || m_tready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tvalid_reg <= 1'b0;
        end
        else if (res_take)
        begin
            m_tvalid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_take)
        begin
            m_tdata_reg <= {2'b00, res.is_empty, res.entry_count, res.position};
            m_tuser_reg <= res.status;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

endmodule

FILE: test/tb_ordered_value_list_engine.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_ordered_value_list_engine
// self-checking bench for the ordered value list engine: a directed table
// walks empty, extreme, duplicate and last-entry cases, then about 900
// random operations in fill, mixed and drain phases reach the full list;
// every result transfer is compared field by field against its typed row
// or, for untyped items, against a behavioral copy of the list kept in
// the bench
module tb_ordered_value_list_engine;

    localparam int RANDOM_OPS  = 900;
    localparam int CALM_FROM   = 800;
    localparam int PHASE_LEN   = 100;
    localparam int HOLD_CYCLES = 40;
    localparam int DRAIN_WAIT  = 80;

    typedef struct {
        ovle_pkg::status_t                st;
        logic [ovle_pkg::POS_W-1:0]       pos;
        logic [ovle_pkg::COUNT_W-1:0]     cnt;
        logic                             empty;
    } outcome_t;

    typedef struct {
        ovle_pkg::op_t                    op;
        logic [ovle_pkg::VALUE_W-1:0]     value;
        bit                               typed;
        ovle_pkg::status_t                st;
        logic [ovle_pkg::POS_W-1:0]       pos;
        logic [ovle_pkg::COUNT_W-1:0]     cnt;
        logic                             empty;
    } table_row_t;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [31:0] s_tdata;   // value[31:0]
    logic [1:0]  s_tuser;   // opcode[1:0]
    logic        m_tvalid;
    logic        m_tready;
    logic [15:0] m_tdata;   // position[5:0], entry_count[12:6], is_empty[13], zero[15:14]
    logic [1:0]  m_tuser;   // status[1:0]

    logic [ovle_pkg::VALUE_W-1:0] list_vals [ovle_pkg::CAPACITY];
    int                           list_len;
    outcome_t                     pending_outcomes [$];
    int                           mismatch_count;
    bit                           row_typed;
    outcome_t                     row_outcome;
    bit                           calm;
    bit                           hold_req;
    bit                           hold_done;

    // directed cases, expectations typed where obvious
    table_row_t directed_rows [25] = '{
        '{ovle_pkg::OP_FIND,   32'h0000_0000, 1'b1, ovle_pkg::ST_EMPTY,     6'd0, 7'd0, 1'b1},
        '{ovle_pkg::OP_REMOVE, 32'h0000_0000, 1'b1, ovle_pkg::ST_EMPTY,     6'd0, 7'd0, 1'b1},
        '{ovle_pkg::OP_CLEAR,  32'h0000_0000, 1'b1, ovle_pkg::ST_DONE,      6'd0, 7'd0, 1'b1},
        '{ovle_pkg::OP_APPEND, 32'h8000_0000, 1'b1, ovle_pkg::ST_DONE,      6'd0, 7'd1, 1'b0},
        '{ovle_pkg::OP_APPEND, 32'h7fff_ffff, 1'b1, ovle_pkg::ST_DONE,      6'd0, 7'd2, 1'b0},
        '{ovle_pkg::OP_APPEND, 32'h0000_0000, 1'b1, ovle_pkg::ST_DONE,      6'd0, 7'd3, 1'b0},
        '{ovle_pkg::OP_APPEND, 32'hffff_ffff, 1'b1, ovle_pkg::ST_DONE,      6'd0, 7'd4, 1'b0},
        '{ovle_pkg::OP_FIND,   32'hffff_ffff, 1'b1, ovle_pkg::ST_DONE,      6'd3, 7'd4, 1'b0},
        '{ovle_pkg::OP_FIND,   32'h8000_0000, 1'b1, ovle_pkg::ST_DONE,      6'd0, 7'd4, 1'b0},
        '{ovle_pkg::OP_FIND,   32'h0000_0001, 1'b1, ovle_pkg::ST_NOT_FOUND, 6'd0, 7'd4, 1'b0},
        '{ovle_pkg::OP_APPEND, 32'h7fff_ffff, 1'b1, ovle_pkg::ST_DONE,      6'd0, 7'd5, 1'b0},
        '{ovle_pkg::OP_FIND,   32'h7fff_ffff, 1'b0, ovle_pkg::ST_DONE,      6'd0, 7'd0, 1'b0},
        '{ovle_pkg::OP_REMOVE, 32'h7fff_ffff, 1'b1, ovle_pkg::ST_DONE,      6'd0, 7'd4, 1'b0},
        '{ovle_pkg::OP_FIND,   32'h7fff_ffff, 1'b0, ovle_pkg::ST_DONE,      6'd0, 7'd0, 1'b0},
        '{ovle_pkg::OP_REMOVE, 32'h7fff_ffff, 1'b1, ovle_pkg::ST_DONE,      6'd0, 7'd3, 1'b0},
        '{ovle_pkg::OP_REMOVE, 32'h0000_3039, 1'b1, ovle_pkg::ST_NOT_FOUND, 6'd0, 7'd3, 1'b0},
        '{ovle_pkg::OP_REMOVE, 32'h8000_0000, 1'b1, ovle_pkg::ST_DONE,      6'd0, 7'd2, 1'b0},
        '{ovle_pkg::OP_FIND,   32'hffff_ffff, 1'b0, ovle_pkg::ST_DONE,      6'd0, 7'd0, 1'b0},
        '{ovle_pkg::OP_CLEAR,  32'hdead_beef, 1'b1, ovle_pkg::ST_DONE,      6'd0, 7'd0, 1'b1},
        '{ovle_pkg::OP_FIND,   32'h0000_0000, 1'b1, ovle_pkg::ST_EMPTY,     6'd0, 7'd0, 1'b1},
        '{ovle_pkg::OP_APPEND, 32'h5555_5555, 1'b1, ovle_pkg::ST_DONE,      6'd0, 7'd1, 1'b0},
        '{ovle_pkg::OP_APPEND, 32'haaaa_aaaa, 1'b1, ovle_pkg::ST_DONE,      6'd0, 7'd2, 1'b0},
        '{ovle_pkg::OP_REMOVE, 32'h5555_5555, 1'b1, ovle_pkg::ST_DONE,      6'd0, 7'd1, 1'b0},
        '{ovle_pkg::OP_FIND,   32'haaaa_aaaa, 1'b0, ovle_pkg::ST_DONE,      6'd0, 7'd0, 1'b0},
        '{ovle_pkg::OP_CLEAR,  32'h0000_0000, 1'b1, ovle_pkg::ST_DONE,      6'd0, 7'd0, 1'b1}
    };

    ordered_value_list_engine uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    initial clk = 1'b0;
    always #6 clk = ~clk;

    initial
    begin
        #(5_000_000);
        $display("Some tests failed");
        $finish;
    end

    task automatic flag_mismatch(input string what, input longint got, input longint want);
        mismatch_count++;
        $display("[%0t] mismatch: %s got %0d want %0d", $realtime, what, got, want);
    endtask

    function automatic outcome_t apply_list_op(input ovle_pkg::op_t op,
                                               input logic [ovle_pkg::VALUE_W-1:0] v);
        outcome_t o;
        int       hit;
        o.st = ovle_pkg::ST_DONE;
        o.pos = '0;
        hit = -1;
        case (op)
            ovle_pkg::OP_APPEND:
            begin
                if (list_len >= ovle_pkg::CAPACITY)
                    o.st = ovle_pkg::ST_FULL;
                else
                begin
                    list_vals[list_len] = v;
                    list_len++;
                end
            end
            ovle_pkg::OP_REMOVE, ovle_pkg::OP_FIND:
            begin
                if (list_len == 0)
                    o.st = ovle_pkg::ST_EMPTY;
                else
                begin
                    for (int i = list_len - 1; i >= 0; i--)
                        if (list_vals[i] == v)
                            hit = i;
                    if (hit < 0)
                        o.st = ovle_pkg::ST_NOT_FOUND;
                    else if (op == ovle_pkg::OP_FIND)
                        o.pos = ovle_pkg::POS_W'(hit);
                    else
                    begin
                        for (int j = hit; j < list_len - 1; j++)
                            list_vals[j] = list_vals[j + 1];
                        list_len--;
                    end
                end
            end
            default:
                list_len = 0;
        endcase
        o.cnt = ovle_pkg::COUNT_W'(list_len);
        o.empty = (list_len == 0);
        return o;
    endfunction

    // result side first: a result leaving at this edge belongs to an older item
    always @(posedge clk)
    begin
        outcome_t want;
        outcome_t got_pred;
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
            begin
                if (pending_outcomes.size() == 0)
                    flag_mismatch("result with nothing pending, m_tdata", m_tdata, 0);
                else
                begin
                    want = pending_outcomes.pop_front();
                    if (m_tuser != want.st)
                        flag_mismatch("status", m_tuser, want.st);
                    if (m_tdata[5:0] != want.pos)
                        flag_mismatch("position", m_tdata[5:0], want.pos);
                    if (m_tdata[12:6] != want.cnt)
                        flag_mismatch("entry_count", m_tdata[12:6], want.cnt);
                    if (m_tdata[13] != want.empty)
                        flag_mismatch("is_empty", m_tdata[13], want.empty);
                    if (m_tdata[15:14] != 2'b00)
                        flag_mismatch("padding", m_tdata[15:14], 0);
                end
            end
            if (s_tvalid && s_tready)
            begin
                got_pred = apply_list_op(ovle_pkg::op_t'(s_tuser), s_tdata);
                pending_outcomes.push_back(row_typed ? row_outcome : got_pred);
            end
        end
    end

    // result receiver: short random stalls, one long hold-off on request
    initial
    begin
        m_tready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_req && !hold_done)
            begin
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
                hold_done = 1'b1;
                m_tready <= 1'b1;
            end
            else if (!calm && $urandom_range(0, 5) == 0)
            begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 4)) @(negedge clk);
                m_tready <= 1'b1;
            end
            else
                m_tready <= 1'b1;
        end
    end

    // called at a falling edge; returns at the falling edge after the transfer
    task automatic push_item(input ovle_pkg::op_t op, input logic [ovle_pkg::VALUE_W-1:0] v,
                             input bit typed, input outcome_t o);
        if (!calm && $urandom_range(0, 5) == 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(negedge clk);
        end
        s_tvalid    <= 1'b1;
        s_tuser     <= op;
        s_tdata     <= v;
        row_typed   <= typed;
        row_outcome <= o;
        do @(posedge clk); while (!s_tready);
        @(negedge clk);
    endtask

    task automatic wait_all_results();
        s_tvalid <= 1'b0;
        do @(negedge clk); while (pending_outcomes.size() != 0);
    endtask

    function automatic ovle_pkg::op_t pick_op(input int mode);
        int r;
        r = $urandom_range(0, 99);
        case (mode)
            0:       return r < 85 ? ovle_pkg::OP_APPEND :
                            (r < 95 ? ovle_pkg::OP_FIND : ovle_pkg::OP_REMOVE);
            2:       return r < 15 ? ovle_pkg::OP_APPEND :
                            (r < 40 ? ovle_pkg::OP_FIND : ovle_pkg::OP_REMOVE);
            default: return r < 3 ? ovle_pkg::OP_CLEAR : (r < 40 ? ovle_pkg::OP_APPEND :
                            (r < 70 ? ovle_pkg::OP_FIND : ovle_pkg::OP_REMOVE));
        endcase
    endfunction

    // stored values most of the time, so searches hit at every depth
    function automatic logic [ovle_pkg::VALUE_W-1:0] pick_value(input ovle_pkg::op_t op);
        int r;
        r = $urandom_range(0, 99);
        if (op != ovle_pkg::OP_APPEND && list_len > 0 && r < 60)
            return list_vals[$urandom_range(0, list_len - 1)];
        if (r < 80)
            case ($urandom_range(0, 5))
                0:       return 32'h0000_0000;
                1:       return 32'hffff_ffff;
                2:       return 32'h8000_0000;
                3:       return 32'h7fff_ffff;
                default: return ovle_pkg::VALUE_W'($urandom_range(0, 7));
            endcase
        return $urandom;
    endfunction

    initial
    begin
        outcome_t      none;
        outcome_t      typed_o;
        ovle_pkg::op_t op;
        none = '{ovle_pkg::ST_DONE, '0, '0, 1'b0};
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = ovle_pkg::OP_APPEND;
        row_typed = 1'b0;
        row_outcome = none;
        calm = 1'b0;
        hold_req = 1'b0;
        hold_done = 1'b0;
        mismatch_count = 0;
        list_len = 0;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        foreach (directed_rows[i])
        begin
            typed_o = '{directed_rows[i].st, directed_rows[i].pos,
                        directed_rows[i].cnt, directed_rows[i].empty};
            push_item(directed_rows[i].op, directed_rows[i].value,
                      directed_rows[i].typed, typed_o);
        end
        wait_all_results();

        for (int n = 0; n < RANDOM_OPS; n++)
        begin
            if (n > 0 && n % PHASE_LEN == 0)
                wait_all_results();
            if (n == 150)
                hold_req = 1'b1;
            if (n == CALM_FROM)
                calm = 1'b1;
            op = pick_op((n / PHASE_LEN) % 4);
            push_item(op, pick_value(op), 1'b0, none);
        end
        s_tvalid <= 1'b0;

        while (pending_outcomes.size() != 0)
            @(negedge clk);
        repeat (DRAIN_WAIT) @(negedge clk);
        if (pending_outcomes.size() != 0)
            flag_mismatch("results never arrived", pending_outcomes.size(), 0);

        if (mismatch_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
